// ----- design/sprite_quad_corner_gen_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SPRITE_QUAD_CORNER_GEN_MACROS_SVH
`define SPRITE_QUAD_CORNER_GEN_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define SQCG_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Usual form inside this project: clk_i and rst_ni.
`define SQCG_CHECK(label, prop, msg) \
  `SQCG_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/sqcg_pkg.sv -----
`timescale 1ns / 1ps
package sqcg_pkg;

  localparam int unsigned TrigIterationsDefault = 16;

  localparam logic [0:0] RegPivotX = 1'b0;
  localparam logic [0:0] RegPivotY = 1'b1;

  localparam logic [1:0] CornerTl = 2'd0;
  localparam logic [1:0] CornerTr = 2'd1;
  localparam logic [1:0] CornerBr = 2'd2;
  localparam logic [1:0] CornerBl = 2'd3;

  localparam int unsigned OutDepth = 4;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [12:0]        tex_width;
    logic [12:0]        tex_height;
    logic [16:0]        uv_left;
    logic [16:0]        uv_top;
    logic [16:0]        uv_width;
    logic [16:0]        uv_height;
    logic [15:0]        angle;
  } sprite_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic [17:0]        tex_u;
    logic [17:0]        tex_v;
    logic               saturated;
    logic               last;
  } corner_t;

  // Corner offsets from the pivot and texture coordinates of one sprite.
  typedef struct packed {
    logic signed [29:0] lx0;
    logic signed [29:0] lx1;
    logic signed [29:0] ly0;
    logic signed [29:0] ly1;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [17:0]        u0;
    logic [17:0]        u1;
    logic [17:0]        v0;
    logic [17:0]        v1;
  } geo_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    geo_t               geo;
  } quad_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turn(input int unsigned idx);
    logic [29:0] r;
    case (idx)
      0: r = 30'd536870912;
      1: r = 30'd316933406;
      2: r = 30'd167458907;
      3: r = 30'd85004756;
      4: r = 30'd42667331;
      5: r = 30'd21354465;
      6: r = 30'd10679838;
      7: r = 30'd5340245;
      8: r = 30'd2670163;
      9: r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/sqcg_fifo.sv -----
`timescale 1ns / 1ps
module sqcg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end
endmodule

// ----- design/sqcg_cordic.sv -----
`timescale 1ns / 1ps
module sqcg_cordic #(
  parameter int unsigned Iterations = 16
) (
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [31:0] c_o,
  output logic signed [31:0] s_o
);
  import sqcg_pkg::*;

  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;
  localparam logic signed [33:0] Gain   = 34'sd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  logic signed [33:0] x_q [Iterations+1];
  logic signed [33:0] y_q [Iterations+1];
  logic signed [33:0] z_q [Iterations+1];
  logic [1:0]         q_q [Iterations+1];

  logic [31:0] a32, d32;
  logic [31:0] qsum;
  logic [1:0]  q0;

  // Reduce to a residual in [-1/8, 1/8) turn and a quarter-turn count.
  always_comb begin
    a32  = {angle_i, 16'd0};
    qsum = a32 + 32'h2000_0000;
    q0   = qsum[31:30];
    d32  = a32 - {q0, 30'd0};
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= Gain;
    y_q[0] <= '0;
    z_q[0] <= 34'(signed'(d32));
    q_q[0] <= q0;
  end

  for (genvar i = 0; i < Iterations; i++) begin : g_iter
    logic signed [33:0] xs, ys, at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = $signed({4'd0, atan_turn(i)});
    always_ff @(posedge clk_i) begin
      if (!z_q[i][33]) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + at;
      end
      q_q[i+1] <= q_q[i];
    end
  end

  logic signed [31:0] xc, yc, c_d, s_d;

  always_comb begin
    if (x_q[Iterations] > OneQ30) begin
      xc = 32'(OneQ30);
    end else if (x_q[Iterations] < -OneQ30) begin
      xc = 32'(-OneQ30);
    end else begin
      xc = 32'(x_q[Iterations]);
    end
    if (y_q[Iterations] > OneQ30) begin
      yc = 32'(OneQ30);
    end else if (y_q[Iterations] < -OneQ30) begin
      yc = 32'(-OneQ30);
    end else begin
      yc = 32'(y_q[Iterations]);
    end
    case (q_q[Iterations])
      Quad0: begin
        c_d = xc;
        s_d = yc;
      end
      Quad1: begin
        c_d = -yc;
        s_d = xc;
      end
      Quad2: begin
        c_d = -xc;
        s_d = -yc;
      end
      default: begin
        c_d = yc;
        s_d = -xc;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    c_o <= c_d;
    s_o <= s_d;
  end
endmodule

// ----- design/sqcg_front.sv -----
`timescale 1ns / 1ps
module sqcg_front #(
  parameter int unsigned TrigIterations = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  sqcg_pkg::sprite_t sprite_i,
  input  logic [16:0]      pivot_x_i,
  input  logic [16:0]      pivot_y_i,
  output logic             vld_o,
  output sqcg_pkg::quad_t  quad_o
);
  import sqcg_pkg::*;

  localparam int unsigned Latency = TrigIterations + 2;
  localparam int unsigned DlyLen  = Latency - 4;

  logic [Latency-1:0] vld_q;

  sprite_t     in1_q, in2_q, in3_q;
  logic [28:0] mx_q, my_q;
  logic [25:0] w_q, h_q, w3_q, h3_q;
  logic [26:0] cx_q, cy_q;
  geo_t        geo_q, geo_d;
  geo_t        dly_q [DlyLen];
  logic signed [31:0] c_w, s_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], accept_i};
    end
  end

  sqcg_cordic #(.Iterations(TrigIterations)) u_cordic (
    .clk_i   (clk_i),
    .angle_i (sprite_i.angle),
    .c_o     (c_w),
    .s_o     (s_w)
  );

  // Size path: products, width and height rounding, then pivot offsets.
  always_ff @(posedge clk_i) begin
    in1_q <= sprite_i;
    mx_q  <= 29'(sprite_i.scale_x) * 29'(sprite_i.tex_width);
    my_q  <= 29'(sprite_i.scale_y) * 29'(sprite_i.tex_height);
    in2_q <= in1_q;
    w_q   <= 26'((46'(mx_q) * 46'(in1_q.uv_width) + 46'h8_0000) >> 20);
    h_q   <= 26'((46'(my_q) * 46'(in1_q.uv_height) + 46'h8_0000) >> 20);
    in3_q <= in2_q;
    w3_q  <= w_q;
    h3_q  <= h_q;
    cx_q  <= 27'((43'(pivot_x_i) * 43'(w_q) + 43'd32768) >> 16);
    cy_q  <= 27'((43'(pivot_y_i) * 43'(h_q) + 43'd32768) >> 16);
    geo_q <= geo_d;
  end

  always_comb begin
    geo_d.lx0   = 30'sd0 - $signed({3'd0, cx_q});
    geo_d.lx1   = $signed({4'd0, w3_q}) - $signed({3'd0, cx_q});
    geo_d.ly0   = 30'sd0 - $signed({3'd0, cy_q});
    geo_d.ly1   = $signed({4'd0, h3_q}) - $signed({3'd0, cy_q});
    geo_d.pos_x = in3_q.pos_x;
    geo_d.pos_y = in3_q.pos_y;
    geo_d.u0    = 18'(in3_q.uv_left);
    geo_d.u1    = 18'(in3_q.uv_left) + 18'(in3_q.uv_width);
    geo_d.v0    = 18'(in3_q.uv_top);
    geo_d.v1    = 18'(in3_q.uv_top) + 18'(in3_q.uv_height);
  end

  // Hold the geometry until the sine and cosine come out.
  always_ff @(posedge clk_i) begin
    dly_q[0] <= geo_q;
  end
  for (genvar i = 1; i < DlyLen; i++) begin : g_dly
    always_ff @(posedge clk_i) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign vld_o      = vld_q[Latency-1];
  assign quad_o.c   = c_w;
  assign quad_o.s   = s_w;
  assign quad_o.geo = dly_q[DlyLen-1];
endmodule

// ----- design/sqcg_back.sv -----
`timescale 1ns / 1ps
module sqcg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mid_empty_i,
  input  sqcg_pkg::quad_t   quad_i,
  output logic              mid_pop_o,
  input  logic              out_pop_i,
  output logic              out_push_o,
  output sqcg_pkg::corner_t out_word_o
);
  import sqcg_pkg::*;

  localparam int unsigned OcntW = $clog2(OutDepth + 1);
  localparam logic signed [61:0] RndHalf = 62'sd536870912;
  localparam logic signed [32:0] VMax = 33'sd8388607;
  localparam logic signed [32:0] VMin = -33'sd8388608;

  quad_t            rec_q;
  logic             have_q, have_d;
  logic [1:0]       k_q;
  logic [OcntW-1:0] ocnt_q, ocnt_d;
  logic             issue, mid_pop, out_pop;

  assign out_pop = out_pop_i;
  assign issue   = have_q && (ocnt_q < OcntW'(OutDepth));
  assign mid_pop = !mid_empty_i && (!have_q || (issue && (k_q == CornerBl)));
  assign mid_pop_o = mid_pop;

  always_comb begin
    have_d = have_q;
    if (mid_pop) begin
      have_d = 1'b1;
    end else if (issue && (k_q == CornerBl)) begin
      have_d = 1'b0;
    end
    ocnt_d = ocnt_q + OcntW'(issue) - OcntW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      k_q    <= CornerTl;
      ocnt_q <= '0;
    end else begin
      have_q <= have_d;
      ocnt_q <= ocnt_d;
      if (issue) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop) begin
      rec_q <= quad_i;
    end
  end

  // Stage A: pick the corner offsets and multiply.
  logic signed [29:0] lx, ly;
  logic               a_vld_q, b_vld_q;
  logic signed [61:0] pcx_q, psy_q, psx_q, pcy_q;
  logic [1:0]         a_k_q, b_k_q;
  logic signed [19:0] a_px_q, a_py_q, b_px_q, b_py_q;
  logic [17:0]        a_u_q, a_v_q, b_u_q, b_v_q;
  logic signed [31:0] rx_q, ry_q;
  logic signed [61:0] sumx, sumy;
  logic signed [32:0] vx, vy;
  logic               sat_x, sat_y;

  always_comb begin
    lx = ((k_q == CornerTr) || (k_q == CornerBr)) ? rec_q.geo.lx1 : rec_q.geo.lx0;
    ly = ((k_q == CornerBr) || (k_q == CornerBl)) ? rec_q.geo.ly1 : rec_q.geo.ly0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= issue;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pcx_q  <= 62'(rec_q.c) * 62'(lx);
    psy_q  <= 62'(rec_q.s) * 62'(ly);
    psx_q  <= 62'(rec_q.s) * 62'(lx);
    pcy_q  <= 62'(rec_q.c) * 62'(ly);
    a_k_q  <= k_q;
    a_px_q <= rec_q.geo.pos_x;
    a_py_q <= rec_q.geo.pos_y;
    a_u_q  <= ((k_q == CornerTr) || (k_q == CornerBr)) ? rec_q.geo.u1 : rec_q.geo.u0;
    a_v_q  <= ((k_q == CornerBr) || (k_q == CornerBl)) ? rec_q.geo.v1 : rec_q.geo.v0;
  end

  // Stage B: combine and round half up out of Q2.30.
  assign sumx = pcx_q - psy_q + RndHalf;
  assign sumy = psx_q + pcy_q + RndHalf;

  always_ff @(posedge clk_i) begin
    rx_q   <= sumx[61:30];
    ry_q   <= sumy[61:30];
    b_k_q  <= a_k_q;
    b_px_q <= a_px_q;
    b_py_q <= a_py_q;
    b_u_q  <= a_u_q;
    b_v_q  <= a_v_q;
  end

  // Stage C: add the anchor and saturate; the queue registers the word.
  always_comb begin
    vx    = 33'(rx_q) + 33'(b_px_q);
    vy    = 33'(ry_q) + 33'(b_py_q);
    sat_x = (vx > VMax) || (vx < VMin);
    sat_y = (vy > VMax) || (vy < VMin);
    out_word_o.corner    = b_k_q;
    out_word_o.vert_x    = (vx > VMax) ? 24'(VMax) : ((vx < VMin) ? 24'(VMin) : vx[23:0]);
    out_word_o.vert_y    = (vy > VMax) ? 24'(VMax) : ((vy < VMin) ? 24'(VMin) : vy[23:0]);
    out_word_o.tex_u     = b_u_q;
    out_word_o.tex_v     = b_v_q;
    out_word_o.saturated = sat_x || sat_y;
    out_word_o.last      = (b_k_q == CornerBl);
  end

  assign out_push_o = b_vld_q;
endmodule

// ----- design/sprite_quad_corner_gen.sv -----
`timescale 1ns / 1ps
// Rotated sprite quad corner generator. Each sprite pushed in yields four corner words
// (top-left, top-right, bottom-right, bottom-left, the last one flagged) with position,
// texture coordinate and a saturation flag. The back end issues one corner per cycle
// while the output queue has room, through its shared rotate multipliers, and takes the
// next sprite from the middle queue as it issues the last corner. The front end computes
// sine and cosine with a pipelined CORDIC. The user must write the pivot registers through
// the cfg port only while the block is idle; the block itself does not enforce this.
module sprite_quad_corner_gen #(
  parameter int unsigned TRIG_ITERATIONS = sqcg_pkg::TrigIterationsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sqcg_pkg::sprite_t sprite_i,
  output logic              empty,
  input  logic              pop,
  output sqcg_pkg::corner_t corner_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [16:0]       cfg_wdata_i
);
  import sqcg_pkg::*;

  localparam int unsigned MidDepth = (TRIG_ITERATIONS + 2) / 4 + 3;
  localparam int unsigned CntW     = $clog2(MidDepth + 1);

  logic [16:0]     pivot_x_q, pivot_y_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept, front_vld, mid_empty, mid_pop, out_push, out_pop;
  quad_t           front_quad, mid_quad;
  corner_t         out_word, out_rd;

  assign accept  = push && !full;
  assign full    = (cnt_q == CntW'(MidDepth));
  assign out_pop = pop && !empty;

  // Every sprite in the front pipeline or the middle queue holds one slot.
  assign cnt_d = cnt_q + CntW'(accept) - CntW'(mid_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pivot_x_q <= '0;
      pivot_y_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i && (cfg_idx_i == RegPivotX)) begin
        pivot_x_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == RegPivotY)) begin
        pivot_y_q <= cfg_wdata_i;
      end
    end
  end

  sqcg_front #(.TrigIterations(TRIG_ITERATIONS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .sprite_i  (sprite_i),
    .pivot_x_i (pivot_x_q),
    .pivot_y_i (pivot_y_q),
    .vld_o     (front_vld),
    .quad_o    (front_quad)
  );

  sqcg_fifo #(.Width($bits(quad_t)), .Depth(MidDepth)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_vld),
    .wdata_i (front_quad),
    .pop_i   (mid_pop),
    .rdata_o (mid_quad),
    .empty_o (mid_empty)
  );

  sqcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .quad_i      (mid_quad),
    .mid_pop_o   (mid_pop),
    .out_pop_i   (out_pop),
    .out_push_o  (out_push),
    .out_word_o  (out_word)
  );

  sqcg_fifo #(.Width($bits(corner_t)), .Depth(OutDepth)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_word),
    .pop_i   (out_pop),
    .rdata_o (out_rd),
    .empty_o (empty)
  );

  assign corner_o = out_rd;
endmodule

// ----- design/sqcg_checker.sv -----
`timescale 1ns / 1ps
`include "sprite_quad_corner_gen_macros.svh"
module sqcg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input sqcg_pkg::corner_t corner_o
);
  import sqcg_pkg::*;

  logic [1:0] exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= CornerTl;
    end else if (pop && !empty) begin
      exp_q <= exp_q + 1'b1;
    end
  end

  `SQCG_CHECK(a_corner_order, !empty |-> corner_o.corner == exp_q, "corner out of order")
  `SQCG_CHECK(a_last_flag, !empty |-> corner_o.last == (corner_o.corner == CornerBl), "bad last flag")
  `SQCG_CHECK(a_sat_clamped, (!empty && corner_o.saturated) |-> (corner_o.vert_x == 24'sh7FFFFF || corner_o.vert_x == 24'sh800000 || corner_o.vert_y == 24'sh7FFFFF || corner_o.vert_y == 24'sh800000), "saturated but not clamped")
  `SQCG_CHECK(a_hold, (!empty && !pop) |=> (!empty && $stable(corner_o)), "result word changed while stalled")
endmodule

bind sprite_quad_corner_gen sqcg_checker u_sqcg_checker (.*);
